// ----- design/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Decimal string multiplier package
// Shared types, codes and digit arithmetic helpers for the multiplier cells
// and their sequencer.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int unsigned RADIX = 10;
  localparam logic [3:0]  DIGIT_MAX = 4'd9;

  // request commands
  typedef enum logic [1:0] {
    CMD_LOAD_A   = 2'd0,
    CMD_LOAD_B   = 2'd1,
    CMD_MULTIPLY = 2'd2
  } dsm_cmd_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MULT,
    ST_FLUSH,
    ST_EMIT
  } dsm_state_e;

  // cell operations
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_CLEAR,
    CELL_ADD,
    CELL_SHIFT_ADD
  } dsm_cell_op_e;

  typedef struct packed {
    dsm_cmd_e   cmd;
    logic [3:0] digit;
    logic       a_negative;
    logic       b_negative;
  } dsm_in_t;

  typedef struct packed {
    logic [3:0] result_digit;
    logic       result_negative;
    logic       last_digit;
    logic       too_long;
  } dsm_out_t;

  // broadcast control for the row of cells
  typedef struct packed {
    dsm_cell_op_e op;
    logic [3:0]   a_digit;
    logic         load_b;
  } dsm_cell_ctrl_t;

  // clamp an incoming digit to the decimal range
  function automatic logic [3:0] sat_digit(input logic [3:0] raw);
    return (raw > DIGIT_MAX) ? DIGIT_MAX : raw;
  endfunction

  // quotient by ten for values up to 127, reciprocal multiply
  function automatic logic [3:0] div10(input logic [6:0] t);
    logic [14:0] p;
    p = 15'(t) * 15'd205;
    return p[14:11];
  endfunction

endpackage

// ----- design/dsm_cell.sv -----
// ----------------------------------------------------------------------------
// Decimal multiplier cell
// One product digit position: holds a sum digit, the pending carry into this
// position and one digit of operand B, and adds a digit product each step.
// ----------------------------------------------------------------------------
module dsm_cell
  import dsm_pkg::*;
(
  input  logic           clk_i,
  input  dsm_cell_ctrl_t ctrl_i,
  input  logic           b_en_i,
  input  logic [3:0]     b_i,
  input  logic [4:0]     sc_i,
  input  logic [3:0]     carry_i,
  output logic [3:0]     b_o,
  output logic [4:0]     sc_o,
  output logic [3:0]     carry_o,
  output logic [3:0]     digit_o,
  output logic           carry_nz_o
);

  logic [3:0] s_q, s_d;
  logic [3:0] c_q, c_d;
  logic [3:0] b_q;
  logic [3:0] b_eff;
  logic [6:0] addend;
  logic [4:0] base;
  logic [6:0] t;
  logic [3:0] q;
  logic [6:0] r;

  assign b_eff  = b_en_i ? b_q : 4'd0;
  assign addend = 7'(ctrl_i.a_digit) * 7'(b_eff);
  assign sc_o   = 5'(s_q) + 5'(c_q);
  assign base   = (ctrl_i.op == CELL_SHIFT_ADD) ? sc_i : sc_o;
  assign t      = 7'(base) + addend;
  assign q      = div10(t);
  assign r      = t - 7'(q) * 7'(RADIX);

  assign carry_o    = q;
  assign digit_o    = s_q;
  assign carry_nz_o = (c_q != 4'd0);
  assign b_o        = b_q;

  always_comb begin
    case (ctrl_i.op)
      CELL_CLEAR: begin
        s_d = 4'd0;
        c_d = 4'd0;
      end
      CELL_ADD, CELL_SHIFT_ADD: begin
        s_d = r[3:0];
        c_d = carry_i;
      end
      default: begin
        s_d = s_q;
        c_d = c_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;
    c_q <= c_d;
    if (ctrl_i.load_b) begin
      b_q <= b_i;
    end
  end

endmodule

// ----- design/decimal_string_multiplier_unit.sv -----
// ----------------------------------------------------------------------------
// Decimal string multiplier
// Signed schoolbook multiplier over decimal digit strings, built as a row of
// digit cells driven by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on in_valid_i/in_ready_o. A load request appends one digit
//   (most significant first) to operand A or B. Digits beyond MAX_DIGITS are
//   dropped and flagged through too_long. A multiply request carries both
//   sign flags and starts the product.
//   Result digits leave on out_valid_o/out_ready_i, most significant first,
//   leading zeros stripped, last_digit marking the final one. An empty
//   operand or a zero product gives a single unsigned 0.
//   Sequence: a multiply runs one shift-and-add step across the cell row per
//   digit of A, ripples carries in place until none is pending, then walks
//   the row out a cell per free output slot, skipped zeros included. Loads
//   are taken back to back while the block is idle.
//   No request is taken while a multiply runs, but the next one is taken as
//   soon as the final digit sits in the output register, even if the
//   receiver stalls. A stall on the output simply holds the row.
//   Reset empties both operands and clears the flag; the row is cleared at
//   the start of every multiply, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
module decimal_string_multiplier_unit
  import dsm_pkg::*;
#(
  parameter int unsigned MAX_DIGITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dsm_in_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output dsm_out_t out_res_o
);

  localparam int unsigned NCELLS = 2 * MAX_DIGITS;
  localparam int unsigned LEN_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned REM_W  = $clog2(NCELLS + 1);

  // sequencer state
  dsm_state_e       state_q, state_d;
  logic [LEN_W-1:0] a_len_q, b_len_q;
  logic             ovf_q;
  logic [LEN_W-1:0] idx_q;
  logic [REM_W-1:0] rem_q;
  logic             emitting_q;
  logic             neg_q;
  logic             out_valid_q;
  dsm_out_t         out_q;

  // operand A store, read in load order
  logic [3:0] a_mem [MAX_DIGITS];

  // cell row
  dsm_cell_ctrl_t cell_ctrl;
  logic [3:0] row_b     [NCELLS];
  logic [4:0] row_sc    [NCELLS];
  logic [3:0] row_carry [NCELLS];
  logic [3:0] row_digit [NCELLS];
  logic [NCELLS-1:0] row_carry_nz;
  logic [NCELLS-1:0] row_b_en;

  logic       in_fire;
  logic       mul_fire;
  logic       a_fire, b_fire;
  logic       any_carry;
  logic       out_free;
  logic [3:0] top_digit;
  logic [3:0] in_digit;
  logic       do_emit;
  logic       emit_step;
  logic       mult_done;

  assign in_fire   = in_valid_i && in_ready_o;
  assign in_digit  = sat_digit(in_req_i.digit);
  assign mul_fire  = in_fire && (in_req_i.cmd == CMD_MULTIPLY);
  assign a_fire    = in_fire && (in_req_i.cmd == CMD_LOAD_A);
  assign b_fire    = in_fire && (in_req_i.cmd == CMD_LOAD_B);
  assign any_carry = |row_carry_nz;
  assign out_free  = !out_valid_q || out_ready_i;
  assign top_digit = row_digit[NCELLS-1];
  assign mult_done = (idx_q == LEN_W'(a_len_q - 1'b1));

  // emit once the first nonzero digit reaches the top, or the last cell
  assign do_emit   = (top_digit != 4'd0) || emitting_q || (rem_q == REM_W'(1));
  assign emit_step = (state_q == ST_EMIT) && out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (mul_fire) begin
          state_d = (a_len_q != '0) ? ST_MULT : ST_FLUSH;
        end
      end
      ST_MULT: begin
        if (mult_done) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!any_carry) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free && (rem_q == REM_W'(1))) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Cell row control
  always_comb begin
    cell_ctrl.op      = CELL_HOLD;
    cell_ctrl.a_digit = 4'd0;
    cell_ctrl.load_b  = b_fire && (b_len_q < LEN_W'(MAX_DIGITS));
    unique case (state_q)
      ST_IDLE: begin
        if (mul_fire) begin
          cell_ctrl.op = CELL_CLEAR;
        end
      end
      ST_MULT: begin
        // Horner step: multiply the row by ten and add one A digit times B
        cell_ctrl.op      = CELL_SHIFT_ADD;
        cell_ctrl.a_digit = a_mem[idx_q[IDX_W-1:0]];
      end
      ST_FLUSH: begin
        // ripple pending carries up in place
        if (any_carry) begin
          cell_ctrl.op = CELL_ADD;
        end
      end
      ST_EMIT: begin
        // shift the digits towards the top cell, one per free output slot
        if (out_free) begin
          cell_ctrl.op = CELL_SHIFT_ADD;
        end
      end
      default: cell_ctrl.op = CELL_HOLD;
    endcase
  end

  // Operand A store
  always_ff @(posedge clk_i) begin
    if (a_fire && (a_len_q < LEN_W'(MAX_DIGITS))) begin
      a_mem[a_len_q[IDX_W-1:0]] <= in_digit;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      a_len_q     <= '0;
      b_len_q     <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      rem_q       <= '0;
      emitting_q  <= 1'b0;
      neg_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (a_fire) begin
        if (a_len_q < LEN_W'(MAX_DIGITS)) begin
          a_len_q <= a_len_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (b_fire) begin
        if (b_len_q < LEN_W'(MAX_DIGITS)) begin
          b_len_q <= b_len_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end

      if (mul_fire) begin
        idx_q      <= '0;
        rem_q      <= REM_W'(NCELLS);
        emitting_q <= 1'b0;
        neg_q      <= in_req_i.a_negative ^ in_req_i.b_negative;
      end

      if (state_q == ST_MULT) begin
        idx_q <= idx_q + 1'b1;
      end

      if (emit_step) begin
        rem_q <= rem_q - 1'b1;
        if (do_emit) begin
          emitting_q <= 1'b1;
        end
        // empty the operands once the final digit goes out
        if (rem_q == REM_W'(1)) begin
          a_len_q <= '0;
          b_len_q <= '0;
          ovf_q   <= 1'b0;
        end
      end

      if (out_free) begin
        out_valid_q <= emit_step && do_emit;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (emit_step && do_emit) begin
      out_q.result_digit    <= top_digit;
      // a zero product reaches the last cell without ever emitting
      out_q.result_negative <= neg_q && (emitting_q || (top_digit != 4'd0));
      out_q.last_digit      <= (rem_q == REM_W'(1));
      out_q.too_long        <= ovf_q;
    end
  end

  // Cell row: cell 0 is the least significant product digit
  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    logic [3:0] b_in;
    logic [4:0] sc_in;
    logic [3:0] carry_in;

    if (k == 0) begin : g_first
      assign b_in     = in_digit;
      assign sc_in    = 5'd0;
      assign carry_in = 4'd0;
    end else begin : g_link
      assign b_in     = row_b[k-1];
      assign sc_in    = row_sc[k-1];
      assign carry_in = row_carry[k-1];
    end

    // only the positions holding loaded B digits take part
    if (k < MAX_DIGITS) begin : g_b_en
      assign row_b_en[k] = (b_len_q > LEN_W'(k));
    end else begin : g_b_off
      assign row_b_en[k] = 1'b0;
    end

    dsm_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .b_en_i     (row_b_en[k]),
      .b_i        (b_in),
      .sc_i       (sc_in),
      .carry_i    (carry_in),
      .b_o        (row_b[k]),
      .sc_o       (row_sc[k]),
      .carry_o    (row_carry[k]),
      .digit_o    (row_digit[k]),
      .carry_nz_o (row_carry_nz[k])
    );
  end

`ifndef SYNTHESIS
  // the row is walked out only after every carry has settled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> !any_carry)
    else $error("carry pending while emitting product digits");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (rem_q != '0))
    else $error("emit counter ran out before the final digit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_len_q <= LEN_W'(MAX_DIGITS)) && (b_len_q <= LEN_W'(MAX_DIGITS)))
    else $error("operand length beyond digit bound");

  // a final digit leaves the block idle for the next request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_step && (rem_q == REM_W'(1))) |=> (state_q == ST_IDLE) && out_valid_q)
    else $error("final digit did not complete the multiply");
`endif

endmodule
